FILE: rtl/core/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types and constants for the SDT service loop parser: byte classes
// passed from the front end to the back end, parser phases, and field codes.
// ----------------------------------------------------------------------------
package sdt_pkg;

   // Default limit on the total section size in bytes
   localparam int unsigned MAX_SECTION_BYTES_DEF = 4096;

   // Section position counter
   localparam int unsigned POS_W = 12;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // Header byte positions
   localparam logic [POS_W-1:0] POS_LEN_HI     = 12'd1;
   localparam logic [POS_W-1:0] POS_LEN_LO     = 12'd2;
   localparam logic [POS_W-1:0] POS_NET_HI     = 12'd8;
   localparam logic [POS_W-1:0] POS_NET_LO     = 12'd9;
   localparam logic [POS_W-1:0] POS_LOOP_START = 12'd10;

   // Bytes before section_length counts, and trailing CRC bytes
   localparam logic [POS_W:0] HDR_PREFIX = 13'd3;
   localparam logic [POS_W:0] CRC_BYTES  = 13'd4;

   // Last byte index of a 5-byte service header
   localparam logic [7:0] SVC_HDR_LAST = 8'd4;

   // Logo transmission descriptor
   localparam logic [7:0] TAG_LOGO       = 8'hCF;
   localparam logic [7:0] LOGO_TYPE_FULL = 8'h01;
   localparam logic [7:0] LOGO_TYPE_ID   = 8'h02;
   localparam logic [7:0] LOGO_TYPE_NAME = 8'h03;

   // Body byte indexes of logo descriptor fields
   localparam logic [7:0] LOGO_K_TYPE   = 8'd0;
   localparam logic [7:0] LOGO_K_ID_HI  = 8'd1;
   localparam logic [7:0] LOGO_K_ID_LO  = 8'd2;
   localparam logic [7:0] LOGO_K_VER_HI = 8'd3;
   localparam logic [7:0] LOGO_K_VER_LO = 8'd4;
   localparam logic [7:0] LOGO_K_DL_HI  = 8'd5;
   localparam logic [7:0] LOGO_K_DL_LO  = 8'd6;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_SERVICE   = 2'd0,
      KIND_LOGO      = 2'd1,
      KIND_NAME      = 2'd2,
      KIND_NAME_LAST = 2'd3
   } kind_type;

   // Byte classes decided by the front end
   typedef enum logic [1:0] {
      CLS_NET_HI = 2'd0,
      CLS_NET_LO = 2'd1,
      CLS_ENTER  = 2'd2,
      CLS_DATA   = 2'd3
   } cls_type;

   // Back end parse phases
   typedef enum logic [2:0] {
      PH_SERVICE = 3'd0,
      PH_TAG     = 3'd1,
      PH_LEN     = 3'd2,
      PH_BODY    = 3'd3,
      PH_SKIP    = 3'd4
   } phase_type;

   // Queue entry
   typedef struct packed {
      cls_type    cls;
      logic [7:0] data;
   } entry_type;

   // Front end to queue
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_push_type;

   // Queue head to back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_head_type;

   // Queue sizing
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

FILE: rtl/core/sdt_req_if.sv
// ----------------------------------------------------------------------------
// sdt_req_if
// Section byte channel: valid/ready handshake with one byte per beat.
// ----------------------------------------------------------------------------
interface sdt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       section_start;

   modport source (output valid, output data_byte, output section_start, input ready);
   modport sink   (input valid, input data_byte, input section_start, output ready);
endinterface

FILE: rtl/core/sdt_rsp_if.sv
// ----------------------------------------------------------------------------
// sdt_rsp_if
// Result channel: valid/ready handshake with one service, logo or name
// record per beat.
// ----------------------------------------------------------------------------
interface sdt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] network_id;
   logic [15:0] service_ident;
   logic        eit_schedule;
   logic        eit_present_following;
   logic [2:0]  running_status;
   logic        free_ca_mode;
   logic [11:0] loop_length;
   logic [7:0]  logo_type;
   logic [15:0] logo_id;
   logic [11:0] logo_version;
   logic [15:0] data_value;

   modport source (
      output valid, output result_kind, output network_id, output service_ident,
      output eit_schedule, output eit_present_following, output running_status,
      output free_ca_mode, output loop_length, output logo_type, output logo_id,
      output logo_version, output data_value,
      input ready
   );
   modport sink (
      input valid, input result_kind, input network_id, input service_ident,
      input eit_schedule, input eit_present_following, input running_status,
      input free_ca_mode, input loop_length, input logo_type, input logo_id,
      input logo_version, input data_value,
      output ready
   );
endinterface

FILE: rtl/core/sdt_front.sv
// ----------------------------------------------------------------------------
// sdt_front
// Accepts section bytes, tracks the position within the section, decodes
// section_length into the end of the service area, and forwards only the
// bytes the back end acts on, tagged with their class.
// ----------------------------------------------------------------------------
module sdt_front #(
   parameter int unsigned MAX_SECTION_BYTES = sdt_pkg::MAX_SECTION_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   sdt_req_if.sink             req_if,
   input  logic                queue_full,
   output sdt_pkg::q_push_type push
);

   localparam logic [sdt_pkg::POS_W:0] MaxBytes = (sdt_pkg::POS_W + 1)'(MAX_SECTION_BYTES);

   logic                       started_ff, started_in;
   logic [sdt_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [sdt_pkg::POS_W-1:0]  end_ff, end_in;

   logic                       accept;
   logic [sdt_pkg::POS_W-1:0]  pos_inc;
   logic [sdt_pkg::POS_W:0]    total;
   logic [sdt_pkg::POS_W:0]    total_clamp;
   logic [sdt_pkg::POS_W-1:0]  end_calc;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && req_if.ready;

   // saturating position
   assign pos_inc = (pos_ff == sdt_pkg::POS_MAX) ? pos_ff : pos_ff + 12'd1;

   // end of service area: min(length + 3, max) - 4, floor zero
   assign total       = {1'b0, end_ff[11:8], req_if.data_byte} + sdt_pkg::HDR_PREFIX;
   assign total_clamp = (total > MaxBytes) ? MaxBytes : total;
   assign end_calc    = (total_clamp > sdt_pkg::CRC_BYTES) ?
                        sdt_pkg::POS_W'(total_clamp - sdt_pkg::CRC_BYTES) : '0;

   // classify each accepted byte
   always_comb begin
      started_in       = started_ff;
      pos_in           = pos_ff;
      end_in           = end_ff;
      push.valid       = 1'b0;
      push.entry.cls   = sdt_pkg::CLS_DATA;
      push.entry.data  = req_if.data_byte;
      if (accept) begin
         if (req_if.section_start) begin
            started_in = 1'b1;
            pos_in     = '0;
         end else if (started_ff) begin
            pos_in = pos_inc;
            if (pos_inc == sdt_pkg::POS_LEN_HI) begin
               end_in = {req_if.data_byte[3:0], 8'h00};
            end else if (pos_inc == sdt_pkg::POS_LEN_LO) begin
               end_in = end_calc;
            end else if (pos_inc == sdt_pkg::POS_NET_HI) begin
               push.valid     = 1'b1;
               push.entry.cls = sdt_pkg::CLS_NET_HI;
            end else if (pos_inc == sdt_pkg::POS_NET_LO) begin
               push.valid     = 1'b1;
               push.entry.cls = sdt_pkg::CLS_NET_LO;
            end else if (pos_inc == sdt_pkg::POS_LOOP_START) begin
               push.valid     = 1'b1;
               push.entry.cls = sdt_pkg::CLS_ENTER;
            end else if (pos_inc > sdt_pkg::POS_LOOP_START && pos_inc < end_ff) begin
               push.valid     = 1'b1;
               push.entry.cls = sdt_pkg::CLS_DATA;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         pos_ff     <= '0;
         end_ff     <= '0;
      end else begin
         started_ff <= started_in;
         pos_ff     <= pos_in;
         end_ff     <= end_in;
      end
   end

endmodule

FILE: rtl/core/sdt_queue.sv
// ----------------------------------------------------------------------------
// sdt_queue
// Short FIFO of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module sdt_queue (
   input  logic                clock,
   input  logic                reset,
   input  sdt_pkg::q_push_type push,
   input  logic                pop,
   output logic                full,
   output sdt_pkg::q_head_type head
);

   localparam logic [sdt_pkg::QUEUE_AW:0] Depth = (sdt_pkg::QUEUE_AW + 1)'(sdt_pkg::QUEUE_DEPTH);

   sdt_pkg::entry_type              mem_ff [sdt_pkg::QUEUE_DEPTH];
   logic [sdt_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sdt_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sdt_pkg::QUEUE_AW:0]      count_ff, count_in;
   logic                            do_push, do_pop;

   assign full       = (count_ff == Depth);
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

FILE: rtl/core/sdt_back.sv
// ----------------------------------------------------------------------------
// sdt_back
// Walks service headers and descriptor loops one byte per beat, decodes
// logo transmission descriptors, and holds the result in an output register.
// ----------------------------------------------------------------------------
module sdt_back (
   input  logic                clock,
   input  logic                reset,
   input  sdt_pkg::q_head_type head,
   output logic                pop,
   sdt_rsp_if.source           rsp_if
);

   // parse state
   sdt_pkg::phase_type phase_ff, phase_in;
   logic [11:0]        rem_ff, rem_in;
   logic [7:0]         fc_ff, fc_in;
   logic [7:0]         tag_ff, tag_in;
   logic [7:0]         len_ff, len_in;
   logic [15:0]        net_ff, net_in;

   // service fields
   logic [15:0]        svc_id_ff, svc_id_in;
   logic               eit_s_ff, eit_s_in;
   logic               eit_pf_ff, eit_pf_in;
   logic [2:0]         run_ff, run_in;
   logic               fca_ff, fca_in;
   logic [11:0]        loop_len_ff, loop_len_in;

   // logo fields
   logic [7:0]         ltype_ff, ltype_in;
   logic [15:0]        lid_ff, lid_in;
   logic [11:0]        lver_ff, lver_in;
   logic [15:0]        ldl_ff, ldl_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   sdt_pkg::kind_type  out_kind_ff;
   logic [15:0]        out_net_ff, out_svc_id_ff, out_lid_ff, out_dval_ff;
   logic               out_eit_s_ff, out_eit_pf_ff, out_fca_ff;
   logic [2:0]         out_run_ff;
   logic [11:0]        out_loop_len_ff, out_lver_ff;
   logic [7:0]         out_ltype_ff;

   // step controls
   logic               can_step, step, step_data;
   logic [7:0]         b;
   logic [11:0]        rem_dec;
   logic [8:0]         fc_inc;
   logic               body_last;
   logic [11:0]        loop_len_next;
   logic               is_logo_tag, type_full, type_id;
   logic               emit, emit_logo;
   sdt_pkg::kind_type  emit_kind;
   logic [15:0]        emit_dval;

   assign can_step      = !out_valid_ff || rsp_if.ready;
   assign step          = head.valid && can_step;
   assign pop           = step;
   assign step_data     = step && (head.entry.cls == sdt_pkg::CLS_DATA);
   assign b             = head.entry.data;
   assign rem_dec       = rem_ff - 12'd1;
   assign fc_inc        = {1'b0, fc_ff} + 9'd1;
   assign body_last     = (fc_inc >= {1'b0, len_ff});
   assign loop_len_next = {loop_len_ff[11:8], b};
   assign is_logo_tag   = (tag_ff == sdt_pkg::TAG_LOGO);
   assign type_full     = (ltype_ff == sdt_pkg::LOGO_TYPE_FULL);
   assign type_id       = (ltype_ff == sdt_pkg::LOGO_TYPE_ID);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (head.entry.cls == sdt_pkg::CLS_ENTER) begin
            phase_in = sdt_pkg::PH_SERVICE;
         end else if (step_data) begin
            case (phase_ff)
               sdt_pkg::PH_SERVICE: begin
                  if (fc_ff >= sdt_pkg::SVC_HDR_LAST) begin
                     phase_in = (loop_len_next != '0) ? sdt_pkg::PH_TAG : sdt_pkg::PH_SERVICE;
                  end
               end
               sdt_pkg::PH_TAG: begin
                  phase_in = (rem_dec != '0) ? sdt_pkg::PH_LEN : sdt_pkg::PH_SERVICE;
               end
               sdt_pkg::PH_LEN: begin
                  if ({4'h0, b} > rem_dec) begin
                     phase_in = (rem_dec != '0) ? sdt_pkg::PH_SKIP : sdt_pkg::PH_SERVICE;
                  end else if (b == 8'h00) begin
                     phase_in = (rem_dec != '0) ? sdt_pkg::PH_TAG : sdt_pkg::PH_SERVICE;
                  end else begin
                     phase_in = sdt_pkg::PH_BODY;
                  end
               end
               sdt_pkg::PH_BODY: begin
                  if (body_last) begin
                     phase_in = (rem_dec != '0) ? sdt_pkg::PH_TAG : sdt_pkg::PH_SERVICE;
                  end
               end
               sdt_pkg::PH_SKIP: begin
                  if (rem_dec == '0) begin
                     phase_in = sdt_pkg::PH_SERVICE;
                  end
               end
               default: begin
                  phase_in = sdt_pkg::PH_SERVICE;
               end
            endcase
         end
      end
   end

   // field capture and result selection
   always_comb begin
      rem_in      = rem_ff;
      fc_in       = fc_ff;
      tag_in      = tag_ff;
      len_in      = len_ff;
      net_in      = net_ff;
      svc_id_in   = svc_id_ff;
      eit_s_in    = eit_s_ff;
      eit_pf_in   = eit_pf_ff;
      run_in      = run_ff;
      fca_in      = fca_ff;
      loop_len_in = loop_len_ff;
      ltype_in    = ltype_ff;
      lid_in      = lid_ff;
      lver_in     = lver_ff;
      ldl_in      = ldl_ff;
      emit        = 1'b0;
      emit_logo   = 1'b0;
      emit_kind   = sdt_pkg::KIND_SERVICE;
      emit_dval   = '0;
      if (step) begin
         case (head.entry.cls)
            sdt_pkg::CLS_NET_HI: begin
               net_in = {b, 8'h00};
            end
            sdt_pkg::CLS_NET_LO: begin
               net_in[7:0] = b;
            end
            sdt_pkg::CLS_ENTER: begin
               fc_in = '0;
            end
            sdt_pkg::CLS_DATA: begin
               case (phase_ff)
                  sdt_pkg::PH_SERVICE: begin
                     // 5-byte service header
                     if (fc_ff == 8'd0) begin
                        svc_id_in   = {b, 8'h00};
                        eit_s_in    = 1'b0;
                        eit_pf_in   = 1'b0;
                        run_in      = '0;
                        fca_in      = 1'b0;
                        loop_len_in = '0;
                     end else if (fc_ff == 8'd1) begin
                        svc_id_in[7:0] = b;
                     end else if (fc_ff == 8'd2) begin
                        eit_s_in  = b[1];
                        eit_pf_in = b[0];
                     end else if (fc_ff == 8'd3) begin
                        run_in            = b[7:5];
                        fca_in            = b[4];
                        loop_len_in[11:8] = b[3:0];
                     end else begin
                        loop_len_in[7:0] = b;
                     end
                     if (fc_ff >= sdt_pkg::SVC_HDR_LAST) begin
                        rem_in    = loop_len_next;
                        fc_in     = '0;
                        emit      = 1'b1;
                        emit_kind = sdt_pkg::KIND_SERVICE;
                     end else begin
                        fc_in = fc_inc[7:0];
                     end
                  end
                  sdt_pkg::PH_TAG: begin
                     tag_in = b;
                     rem_in = rem_dec;
                     fc_in  = '0;
                  end
                  sdt_pkg::PH_LEN: begin
                     len_in = b;
                     rem_in = rem_dec;
                     fc_in  = '0;
                  end
                  sdt_pkg::PH_BODY: begin
                     rem_in = rem_dec;
                     if (is_logo_tag) begin
                        if (fc_ff == sdt_pkg::LOGO_K_TYPE) begin
                           ltype_in = b;
                           lid_in   = '0;
                           lver_in  = '0;
                           ldl_in   = '0;
                        end else if (type_full || type_id) begin
                           if (fc_ff == sdt_pkg::LOGO_K_ID_HI) begin
                              lid_in[15:8] = b;
                           end else if (fc_ff == sdt_pkg::LOGO_K_ID_LO) begin
                              lid_in[7:0] = b;
                           end else if (type_full && fc_ff == sdt_pkg::LOGO_K_VER_HI) begin
                              lver_in[11:8] = b[3:0];
                           end else if (type_full && fc_ff == sdt_pkg::LOGO_K_VER_LO) begin
                              lver_in[7:0] = b;
                           end else if (type_full && fc_ff == sdt_pkg::LOGO_K_DL_HI) begin
                              ldl_in[15:8] = b;
                           end else if (type_full && fc_ff == sdt_pkg::LOGO_K_DL_LO) begin
                              ldl_in[7:0] = b;
                           end
                           if ((type_id && fc_ff == sdt_pkg::LOGO_K_ID_LO) ||
                               (type_full && fc_ff == sdt_pkg::LOGO_K_DL_LO)) begin
                              emit      = 1'b1;
                              emit_logo = 1'b1;
                              emit_kind = sdt_pkg::KIND_LOGO;
                              emit_dval = type_full ? ldl_in : '0;
                           end
                        end else if (ltype_ff == sdt_pkg::LOGO_TYPE_NAME) begin
                           // one name byte per result, last one flagged
                           emit      = 1'b1;
                           emit_logo = 1'b1;
                           emit_kind = (fc_inc == {1'b0, len_ff}) ?
                                       sdt_pkg::KIND_NAME_LAST : sdt_pkg::KIND_NAME;
                           emit_dval = {8'h00, b};
                        end
                     end
                     fc_in = body_last ? '0 : fc_inc[7:0];
                  end
                  sdt_pkg::PH_SKIP: begin
                     rem_in = rem_dec;
                     if (rem_dec == '0) begin
                        fc_in = '0;
                     end
                  end
                  default: begin
                     fc_in = fc_ff;
                  end
               endcase
            end
            default: begin
               fc_in = fc_ff;
            end
         endcase
      end
   end

   // output valid: load on a result, clear when taken
   assign out_valid_in = step ? emit : (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sdt_pkg::PH_SERVICE;
         rem_ff       <= '0;
         fc_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rem_ff       <= rem_in;
         fc_ff        <= fc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // field registers, no reset
   always_ff @(posedge clock) begin
      tag_ff      <= tag_in;
      len_ff      <= len_in;
      net_ff      <= net_in;
      svc_id_ff   <= svc_id_in;
      eit_s_ff    <= eit_s_in;
      eit_pf_ff   <= eit_pf_in;
      run_ff      <= run_in;
      fca_ff      <= fca_in;
      loop_len_ff <= loop_len_in;
      ltype_ff    <= ltype_in;
      lid_ff      <= lid_in;
      lver_ff     <= lver_in;
      ldl_ff      <= ldl_in;
   end

   // result payload
   always_ff @(posedge clock) begin
      if (step && emit) begin
         out_kind_ff     <= emit_kind;
         out_net_ff      <= net_in;
         out_svc_id_ff   <= svc_id_in;
         out_eit_s_ff    <= eit_s_in;
         out_eit_pf_ff   <= eit_pf_in;
         out_run_ff      <= run_in;
         out_fca_ff      <= fca_in;
         out_loop_len_ff <= loop_len_in;
         out_ltype_ff    <= emit_logo ? ltype_in : '0;
         out_lid_ff      <= emit_logo ? lid_in : '0;
         out_lver_ff     <= emit_logo ? lver_in : '0;
         out_dval_ff     <= emit_dval;
      end
   end

   assign rsp_if.valid                 = out_valid_ff;
   assign rsp_if.result_kind           = out_kind_ff;
   assign rsp_if.network_id            = out_net_ff;
   assign rsp_if.service_ident         = out_svc_id_ff;
   assign rsp_if.eit_schedule          = out_eit_s_ff;
   assign rsp_if.eit_present_following = out_eit_pf_ff;
   assign rsp_if.running_status        = out_run_ff;
   assign rsp_if.free_ca_mode          = out_fca_ff;
   assign rsp_if.loop_length           = out_loop_len_ff;
   assign rsp_if.logo_type             = out_ltype_ff;
   assign rsp_if.logo_id               = out_lid_ff;
   assign rsp_if.logo_version          = out_lver_ff;
   assign rsp_if.data_value            = out_dval_ff;

endmodule

FILE: rtl/core/sdt_service_loop_parser.sv
// ----------------------------------------------------------------------------
// sdt_service_loop_parser
// Byte-serial SDT section parser: emits service records, logo records and
// logo name bytes from service descriptor loops.
// ----------------------------------------------------------------------------
// Throughput: one section byte per cycle, sustained while rsp_if.ready is high.
// Path: a byte's result is registered through the front end classify into a
//   2-entry queue, then through the back end step into the output reg.
// Reset: synchronous, active high; clears position, queue and result valid.
//   The parser then ignores bytes until the next section_start.
// ----------------------------------------------------------------------------
module sdt_service_loop_parser #(
   parameter int unsigned MAX_SECTION_BYTES = sdt_pkg::MAX_SECTION_BYTES_DEF
) (
   input logic       clock,
   input logic       reset,
   sdt_req_if.sink   req_if,
   sdt_rsp_if.source rsp_if
);

   sdt_pkg::q_push_type push;
   sdt_pkg::q_head_type head;
   logic                queue_full;
   logic                pop;

   // front end: position tracking and byte classification
   sdt_front #(
      .MAX_SECTION_BYTES (MAX_SECTION_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push)
   );

   // decoupling queue
   sdt_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // back end: service and descriptor loop parsing
   sdt_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SDT service loop parser. Directed and random
// service description sections are streamed one byte per beat. Every record
// on the result channel is compared with a cycle-free model of the parser
// that runs inside the bench.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SECTION_LIMIT = sdt_pkg::MAX_SECTION_BYTES_DEF;
   localparam int unsigned TARGET_BEATS  = 1300;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned DRAIN_CYCLES  = 16;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned MAX_REPORTS   = 10;

   // Parser phases as the model sees them
   typedef enum logic [2:0] {
      ST_IDLE, ST_HEADER, ST_SERVICE, ST_TAG, ST_LEN, ST_BODY, ST_SKIP, ST_TAIL
   } parse_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       section_start;
   } byte_beat_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] network_id;
      logic [15:0] service_ident;
      logic        eit_schedule;
      logic        eit_present_following;
      logic [2:0]  running_status;
      logic        free_ca_mode;
      logic [11:0] loop_length;
      logic [7:0]  logo_type;
      logic [15:0] logo_id;
      logic [11:0] logo_version;
      logic [15:0] data_value;
   } record_type;

   logic clock = 1'b0;
   logic reset;
   logic hold = 1'b0;
   logic steady;

   sdt_req_if req_if ();
   sdt_rsp_if rsp_if ();

   sdt_service_loop_parser u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Parser model state
   parse_state_type pst       = ST_IDLE;
   logic [11:0]     pos       = '0;
   logic [11:0]     area_end  = '0;
   logic [15:0]     net_word  = '0;
   logic [35:0]     svc_word  = '0;
   logic [11:0]     loop_left = '0;
   logic [7:0]      body_idx  = '0;
   logic [15:0]     tag_len   = '0;
   logic [51:0]     logo_word = '0;

   record_type    expected_q[$];
   byte_beat_type pending_q[$];
   logic [7:0]    area_q[$];   // service area of the section being built
   logic [7:0]    loop_q[$];   // descriptor loop of the service being built

   int unsigned beats_in = 0;
   int unsigned total_beats;
   int unsigned sections_built = 0;
   int unsigned records_seen = 0;
   int unsigned kind_seen [4] = '{0, 0, 0, 0};
   int unsigned errors = 0;
   int unsigned cycle_count = 0;

   // Record of the current service, with or without logo fields
   function automatic record_type make_record(input logic [1:0] kind, input bit with_logo,
                                              input logic [15:0] dval);
      record_type r;
      r.kind                  = kind;
      r.network_id            = net_word;
      r.service_ident         = svc_word[15:0];
      r.eit_schedule          = svc_word[16];
      r.eit_present_following = svc_word[17];
      r.running_status        = svc_word[20:18];
      r.free_ca_mode          = svc_word[21];
      r.loop_length           = svc_word[33:22];
      r.logo_type             = with_logo ? logo_word[7:0] : '0;
      r.logo_id               = with_logo ? logo_word[23:8] : '0;
      r.logo_version          = with_logo ? logo_word[35:24] : '0;
      r.data_value            = with_logo ? dval : '0;
      return r;
   endfunction

   function automatic string record_text(input record_type r);
      return $sformatf("kind=%0d net=%h svc=%h eit=%b%b rs=%0d ca=%b loop=%0d type=%h id=%h ver=%h data=%h",
                       r.kind, r.network_id, r.service_ident, r.eit_schedule,
                       r.eit_present_following, r.running_status, r.free_ca_mode,
                       r.loop_length, r.logo_type, r.logo_id, r.logo_version, r.data_value);
   endfunction

   // Next descriptor, or next service header once the loop is used up
   task automatic loop_or_next();
      body_idx = '0;
      pst = (loop_left != 0) ? ST_TAG : ST_SERVICE;
   endtask

   // Advance the model by one accepted byte, queueing any record it yields
   task automatic parse_byte(input logic [7:0] b, input logic start);
      int unsigned total;
      logic [7:0]  k;
      logic [7:0]  len;
      logic [7:0]  ltype;
      logic [35:0] v;
      if (start) begin
         pos = '0;
         pst = ST_HEADER;
         return;
      end
      if (pst == ST_IDLE || pst == ST_TAIL) return;
      if (pos != sdt_pkg::POS_MAX) pos = pos + 1'b1;

      // Section header: length, network id, then into the service area
      if (pst == ST_HEADER) begin
         if (pos == sdt_pkg::POS_LEN_HI) begin
            area_end = {b[3:0], 8'h00};
         end else if (pos == sdt_pkg::POS_LEN_LO) begin
            total = int'({area_end[11:8], b}) + 3;
            if (total > SECTION_LIMIT) total = SECTION_LIMIT;
            area_end = (total > 4) ? 12'(total - 4) : '0;
         end else if (pos == sdt_pkg::POS_NET_HI) begin
            net_word = {b, 8'h00};
         end else if (pos == sdt_pkg::POS_NET_LO) begin
            net_word[7:0] = b;
         end else if (pos >= sdt_pkg::POS_LOOP_START) begin
            pst = ST_SERVICE;
            body_idx = '0;
         end
         return;
      end

      // Past the service area: wait for the next section
      if (pos >= area_end) begin
         pst = ST_TAIL;
         return;
      end

      case (pst)
         ST_SERVICE: begin
            k = body_idx;
            v = svc_word;
            case (k)
               8'd0:    v = 36'(b) << 8;
               8'd1:    v = v | 36'(b);
               8'd2:    v = v | (36'(b[1]) << 16) | (36'(b[0]) << 17);
               8'd3:    v = v | (36'(b[7:5]) << 18) | (36'(b[4]) << 21) | (36'(b[3:0]) << 30);
               default: v = v | (36'(b) << 22);
            endcase
            svc_word = v;
            if (k >= sdt_pkg::SVC_HDR_LAST) begin
               loop_left = svc_word[33:22];
               loop_or_next();
               expected_q.insert(expected_q.size(),
                                 make_record(sdt_pkg::KIND_SERVICE, 1'b0, '0));
            end else begin
               body_idx = k + 1'b1;
            end
         end
         ST_TAG: begin
            tag_len = {b, 8'h00};
            loop_left = loop_left - 1'b1;
            pst = (loop_left != 0) ? ST_LEN : ST_SERVICE;
            body_idx = '0;
         end
         ST_LEN: begin
            tag_len[7:0] = b;
            loop_left = loop_left - 1'b1;
            body_idx = '0;
            if ({4'd0, b} > loop_left) pst = (loop_left != 0) ? ST_SKIP : ST_SERVICE;
            else if (b == 8'd0) loop_or_next();
            else pst = ST_BODY;
         end
         ST_BODY: begin
            k = body_idx;
            len = tag_len[7:0];
            loop_left = loop_left - 1'b1;
            if (tag_len[15:8] == sdt_pkg::TAG_LOGO) begin
               if (k == sdt_pkg::LOGO_K_TYPE) logo_word = 52'(b);
               ltype = logo_word[7:0];
               if (k != sdt_pkg::LOGO_K_TYPE &&
                   (ltype == sdt_pkg::LOGO_TYPE_FULL || ltype == sdt_pkg::LOGO_TYPE_ID)) begin
                  if (k == sdt_pkg::LOGO_K_ID_HI) logo_word |= 52'(b) << 16;
                  else if (k == sdt_pkg::LOGO_K_ID_LO) logo_word |= 52'(b) << 8;
                  else if (ltype == sdt_pkg::LOGO_TYPE_FULL) begin
                     if (k == sdt_pkg::LOGO_K_VER_HI) logo_word |= 52'(b[3:0]) << 32;
                     else if (k == sdt_pkg::LOGO_K_VER_LO) logo_word |= 52'(b) << 24;
                     else if (k == sdt_pkg::LOGO_K_DL_HI) logo_word |= 52'(b) << 44;
                     else if (k == sdt_pkg::LOGO_K_DL_LO) logo_word |= 52'(b) << 36;
                  end
                  if ((ltype == sdt_pkg::LOGO_TYPE_ID && k == sdt_pkg::LOGO_K_ID_LO) ||
                      (ltype == sdt_pkg::LOGO_TYPE_FULL && k == sdt_pkg::LOGO_K_DL_LO))
                     expected_q.insert(expected_q.size(), make_record(sdt_pkg::KIND_LOGO, 1'b1,
                        (ltype == sdt_pkg::LOGO_TYPE_FULL) ? logo_word[51:36] : 16'h0000));
               end else if (k != sdt_pkg::LOGO_K_TYPE && ltype == sdt_pkg::LOGO_TYPE_NAME) begin
                  expected_q.insert(expected_q.size(), make_record(
                     (int'(k) + 1 == int'(len)) ? sdt_pkg::KIND_NAME_LAST : sdt_pkg::KIND_NAME,
                     1'b1, {8'h00, b}));
               end
            end
            if (int'(k) + 1 >= int'(len)) loop_or_next();
            else body_idx = k + 1'b1;
         end
         ST_SKIP: begin
            loop_left = loop_left - 1'b1;
            if (loop_left == 0) begin
               pst = ST_SERVICE;
               body_idx = '0;
            end
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------
   task automatic push_beat(input logic [7:0] b, input logic s);
      byte_beat_type e;
      e.data_byte = b;
      e.section_start = s;
      pending_q.insert(pending_q.size(), e);
   endtask

   // Descriptor: tag, length byte, then a body led by the type byte.
   // fill < 0 gives random body bytes, else every byte after the type is fill.
   task automatic add_desc(input logic [7:0] tag, input logic [7:0] dlen,
                           input logic [7:0] first, input int unsigned nbody, input int fill);
      loop_q.insert(loop_q.size(), tag);
      loop_q.insert(loop_q.size(), dlen);
      for (int i = 0; i < nbody; i++) begin
         if (i == 0) loop_q.insert(loop_q.size(), first);
         else if (fill < 0) loop_q.insert(loop_q.size(), 8'($urandom));
         else loop_q.insert(loop_q.size(), 8'(fill));
      end
   endtask

   // Service header plus the loop built so far; loop_len < 0 means the true size
   task automatic add_service(input logic [15:0] sid, input logic [7:0] flags,
                              input logic [3:0] rs_ca, input int loop_len);
      logic [11:0] len12;
      len12 = (loop_len < 0) ? 12'(loop_q.size()) : 12'(loop_len);
      area_q.insert(area_q.size(), sid[15:8]);
      area_q.insert(area_q.size(), sid[7:0]);
      area_q.insert(area_q.size(), flags);
      area_q.insert(area_q.size(), {rs_ca, len12[11:8]});
      area_q.insert(area_q.size(), len12[7:0]);
      foreach (loop_q[i]) area_q.insert(area_q.size(), loop_q[i]);
      loop_q.delete();
   endtask

   // Header, service area and CRC; sec_len < 0 means the true length,
   // cut >= 0 keeps only that many bytes so the next section cuts it off
   task automatic finish_section(input logic [15:0] net, input int sec_len, input int cut);
      logic [11:0] slen;
      logic [7:0]  sec_q[$];
      int unsigned keep;
      slen = (sec_len < 0) ? 12'(area_q.size() + 12) : 12'(sec_len);
      sec_q.insert(sec_q.size(), 8'($urandom));
      sec_q.insert(sec_q.size(), {4'($urandom), slen[11:8]});
      sec_q.insert(sec_q.size(), slen[7:0]);
      repeat (5) sec_q.insert(sec_q.size(), 8'($urandom));
      sec_q.insert(sec_q.size(), net[15:8]);
      sec_q.insert(sec_q.size(), net[7:0]);
      sec_q.insert(sec_q.size(), 8'($urandom));
      foreach (area_q[i]) sec_q.insert(sec_q.size(), area_q[i]);
      repeat (4) sec_q.insert(sec_q.size(), 8'($urandom));
      area_q.delete();
      keep = (cut < 0 || cut > int'(sec_q.size())) ? sec_q.size() : cut;
      for (int i = 0; i < keep; i++) push_beat(sec_q[i], i == 0);
      sections_built++;
   endtask

   task automatic random_desc();
      logic [7:0]  tag;
      logic [7:0]  ltype;
      logic [7:0]  dlen;
      int unsigned n;
      int unsigned pick;
      tag = ($urandom_range(0, 99) < 75) ? sdt_pkg::TAG_LOGO : 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         ltype = sdt_pkg::LOGO_TYPE_FULL;
         n = 7 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      end else if (pick < 5) begin
         ltype = sdt_pkg::LOGO_TYPE_ID;
         n = 3;
      end else if (pick < 8) begin
         ltype = sdt_pkg::LOGO_TYPE_NAME;
         n = 1 + $urandom_range(0, 6);
      end else begin
         ltype = 8'($urandom);
         n = $urandom_range(0, 6);
      end
      // rare body of the largest size
      if ($urandom_range(0, 99) < 2) n = 255;
      pick = $urandom_range(0, 99);
      // short body that the length byte still matches
      if (pick < 15) n = $urandom_range(0, n);
      dlen = 8'(n);
      // length byte that disagrees with the body
      if (pick >= 90) dlen = 8'($urandom_range(0, 12));
      add_desc(tag, dlen, ltype, n, -1);
   endtask

   task automatic random_section();
      int unsigned pick;
      int          sec_len;
      int          cut;
      repeat ($urandom_range(0, 3)) begin
         repeat ($urandom_range(0, 3)) random_desc();
         // lone tag as the last loop byte
         if ($urandom_range(0, 99) < 10) loop_q.insert(loop_q.size(), 8'($urandom));
         add_service(16'($urandom), 8'($urandom), 4'($urandom),
                     ($urandom_range(0, 99) < 85) ? -1 : int'($urandom_range(0, 40)));
      end
      pick = $urandom_range(0, 99);
      sec_len = -1;
      cut = -1;
      if (pick < 8) begin
         sec_len = int'($urandom_range(0, 4095));
      end else if (pick < 16) begin
         sec_len = int'(area_q.size()) + 12 - int'($urandom_range(0, 16));
         if (sec_len < 0) sec_len = 0;
      end else if (pick < 26) begin
         cut = int'($urandom_range(1, area_q.size() + 14));
      end
      finish_section(16'($urandom), sec_len, cut);
   endtask

   task automatic build_stimulus();
      // bytes ahead of any section start are ignored
      push_beat(8'h00, 1'b0);
      push_beat(8'hFF, 1'b0);

      // zero service fields; full, id-only and name logos, a short full logo,
      // an empty descriptor, a foreign tag and an unknown logo type
      add_desc(sdt_pkg::TAG_LOGO, 8'd7, sdt_pkg::LOGO_TYPE_FULL, 7, 'hFF);
      add_desc(sdt_pkg::TAG_LOGO, 8'd3, sdt_pkg::LOGO_TYPE_ID, 3, 0);
      add_desc(sdt_pkg::TAG_LOGO, 8'd3, sdt_pkg::LOGO_TYPE_NAME, 3, -1);
      add_desc(sdt_pkg::TAG_LOGO, 8'd4, sdt_pkg::LOGO_TYPE_FULL, 4, -1);
      add_desc(8'h48, 8'd0, 8'h00, 0, -1);
      add_desc(sdt_pkg::TAG_LOGO, 8'd1, 8'h07, 1, -1);
      add_service(16'h0000, 8'h00, 4'h0, -1);
      finish_section(16'h0000, -1, -1);

      // all-ones header fields and the largest section length; a loop that
      // ends on its tag byte, then a descriptor overrunning its loop
      loop_q.insert(loop_q.size(), sdt_pkg::TAG_LOGO);
      add_service(16'hFFFF, 8'hFF, 4'hF, -1);
      add_desc(sdt_pkg::TAG_LOGO, 8'd9, sdt_pkg::LOGO_TYPE_FULL, 3, -1);
      add_service(16'h1234, 8'h02, 4'hA, 5);
      add_desc(sdt_pkg::TAG_LOGO, 8'd7, sdt_pkg::LOGO_TYPE_FULL, 7, -1);
      add_service(16'hA5A5, 8'h01, 4'h5, -1);
      finish_section(16'hFFFF, 4095, -1);

      // section lengths that leave no service area
      add_service(16'($urandom), 8'($urandom), 4'($urandom), -1);
      finish_section(16'($urandom), 0, -1);
      add_service(16'($urandom), 8'($urandom), 4'($urandom), -1);
      finish_section(16'($urandom), 1, -1);

      // section cut off inside a logo descriptor
      add_desc(sdt_pkg::TAG_LOGO, 8'd7, sdt_pkg::LOGO_TYPE_FULL, 7, -1);
      add_service(16'($urandom), 8'($urandom), 4'($urandom), -1);
      finish_section(16'($urandom), -1, 20);

      // random part: mostly well-formed sections, some noise
      while (pending_q.size() < TARGET_BEATS) begin
         if ($urandom_range(0, 99) < 5)
            repeat ($urandom_range(1, 6)) push_beat(8'($urandom), 1'b0);
         else
            random_section();
      end
   endtask

   // ------------------------------------------------------------------
   // Byte driver
   // ------------------------------------------------------------------
   assign steady = (beats_in >= 900) && (beats_in < 1150);

   always @(posedge clock) begin
      byte_beat_type beat;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= 35)) begin
            beat = pending_q.pop_front();
            req_if.valid         <= 1'b1;
            req_if.data_byte     <= beat.data_byte;
            req_if.section_start <= beat.section_start;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result ready: random stalls, plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= !hold && (steady || $urandom_range(0, 99) >= 35);
   end

   initial begin
      wait (beats_in >= 400);
      @(posedge clock);
      hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Monitor: model every accepted byte, check every accepted record
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      record_type got;
      record_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            parse_byte(req_if.data_byte, req_if.section_start);
            beats_in <= beats_in + 1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind                  = rsp_if.result_kind;
            got.network_id            = rsp_if.network_id;
            got.service_ident         = rsp_if.service_ident;
            got.eit_schedule          = rsp_if.eit_schedule;
            got.eit_present_following = rsp_if.eit_present_following;
            got.running_status        = rsp_if.running_status;
            got.free_ca_mode          = rsp_if.free_ca_mode;
            got.loop_length           = rsp_if.loop_length;
            got.logo_type             = rsp_if.logo_type;
            got.logo_id               = rsp_if.logo_id;
            got.logo_version          = rsp_if.logo_version;
            got.data_value            = rsp_if.data_value;
            if (expected_q.size() == 0) begin
               if (errors < MAX_REPORTS) $display("Unexpected record: %s", record_text(got));
               errors++;
            end else begin
               want = expected_q.pop_front();
               kind_seen[want.kind]++;
               if (got !== want) begin
                  if (errors < MAX_REPORTS) begin
                     $display("Record %0d mismatch", records_seen);
                     $display("  expected %s", record_text(want));
                     $display("  actual   %s", record_text(got));
                  end
                  errors++;
               end
            end
            records_seen++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d records still expected",
                  cycle_count, expected_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence: reset, run, drain, report
   // ------------------------------------------------------------------
   initial begin
      req_if.valid         = 1'b0;
      req_if.data_byte     = '0;
      req_if.section_start = 1'b0;
      rsp_if.ready         = 1'b0;
      reset                = 1'b1;
      build_stimulus();
      total_beats = pending_q.size();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (beats_in < total_beats) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_q.size() != 0) begin
         $display("%0d expected records never arrived", expected_q.size());
         errors += expected_q.size();
      end
      $display("Covered %0d section bytes in %0d built sections, with a %0d-cycle output stall",
               total_beats, sections_built, HOLD_CYCLES);
      $display("Checked %0d records (%0d service, %0d logo, %0d name bytes), %0d errors",
               records_seen, kind_seen[0], kind_seen[1], kind_seen[2] + kind_seen[3], errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/sdt_pkg.sv
rtl/core/sdt_req_if.sv
rtl/core/sdt_rsp_if.sv
rtl/core/sdt_front.sv
rtl/core/sdt_queue.sv
rtl/core/sdt_back.sv
rtl/core/sdt_service_loop_parser.sv
tb/sv/testbench.sv
